FILE: design/wspd_pkg.sv
// ----------------------------------------------------------------------------
// wspd_pkg: shared types and constants for the wheel speed PD controller
// Control word layout, datapath select codes, microcode program and widths.
// ----------------------------------------------------------------------------
package wspd_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIFF_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OVER_LIM  = 3'd4;

  // Operation codes on in_tuser
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // Datapath widths
  localparam int MA_W    = 42;            // multiplier operand A, signed
  localparam int MB_W    = 15;            // multiplier operand B, signed
  localparam int PROD_W  = MA_W + MB_W;   // product register
  localparam int ACC_W   = 44;            // accumulator
  localparam int SUM_W   = 14;            // signed count sum
  localparam int TICK_W  = 7;             // clamped tick, covers RAMP_STEPS up to 127
  localparam int DIG_W   = 4;             // quotient bits per divide step
  localparam int DVD_W   = 48;            // ramp dividend magnitude
  localparam int DIV_STEPS = DVD_W / DIG_W;
  localparam int REM_W   = 7;             // remainder, below RAMP_STEPS
  localparam int CUR_W   = REM_W + DIG_W;
  localparam int Q_W     = 42;            // quotient bits kept for the ramp add
  localparam int CNT_W   = 4;
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

  // Microcode
  localparam int UPC_W = 4;
  localparam logic [UPC_W-1:0] SAMPLE_ENTRY = 4'd0;
  localparam logic [UPC_W-1:0] TICK_ENTRY   = 4'd7;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_SPEED,
    MUL_PROP,
    MUL_DIFF,
    MUL_TICK
  } mul_sel_t;

  typedef enum logic [3:0] {
    ALU_NONE,
    ALU_SPEED,
    ALU_ERR,
    ALU_EDIFF,
    ALU_ACC_LD,
    ALU_ACC_ADD,
    ALU_ODIFF,
    ALU_DIV_INIT,
    ALU_DIV_STEP,
    ALU_RAMP
  } alu_t;

  typedef enum logic [1:0] {
    BR_NEXT,
    BR_LOOP,
    BR_END
  } br_t;

  typedef struct packed {
    mul_sel_t         mul;
    alu_t             alu;
    logic             commit;
    logic             emit;
    br_t              br;
    logic [UPC_W-1:0] target;
  } ucode_t;

  // Control group from sequencer to datapath, already gated by stall
  typedef struct packed {
    mul_sel_t mul;
    alu_t     alu;
    logic     commit;
    logic     emit;
  } ctl_t;

  // Program: sample at SAMPLE_ENTRY, ramp tick at TICK_ENTRY
  function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] upc);
    ucode_t w;
    w = '{MUL_NONE, ALU_NONE, 1'b0, 1'b0, BR_END, '0};
    case (upc)
      4'd0:  w = '{MUL_SPEED, ALU_NONE,     1'b0, 1'b0, BR_NEXT, '0};
      4'd1:  w = '{MUL_NONE,  ALU_SPEED,    1'b0, 1'b0, BR_NEXT, '0};
      4'd2:  w = '{MUL_NONE,  ALU_ERR,      1'b0, 1'b0, BR_NEXT, '0};
      4'd3:  w = '{MUL_PROP,  ALU_EDIFF,    1'b0, 1'b0, BR_NEXT, '0};
      4'd4:  w = '{MUL_DIFF,  ALU_ACC_LD,   1'b0, 1'b0, BR_NEXT, '0};
      4'd5:  w = '{MUL_NONE,  ALU_ACC_ADD,  1'b0, 1'b0, BR_NEXT, '0};
      4'd6:  w = '{MUL_NONE,  ALU_NONE,     1'b1, 1'b1, BR_END,  '0};
      4'd7:  w = '{MUL_NONE,  ALU_ODIFF,    1'b0, 1'b0, BR_NEXT, '0};
      4'd8:  w = '{MUL_TICK,  ALU_NONE,     1'b0, 1'b0, BR_NEXT, '0};
      4'd9:  w = '{MUL_NONE,  ALU_DIV_INIT, 1'b0, 1'b0, BR_NEXT, '0};
      4'd10: w = '{MUL_NONE,  ALU_DIV_STEP, 1'b0, 1'b0, BR_LOOP, 4'd10};
      4'd11: w = '{MUL_NONE,  ALU_RAMP,     1'b0, 1'b0, BR_NEXT, '0};
      4'd12: w = '{MUL_NONE,  ALU_NONE,     1'b0, 1'b1, BR_END,  '0};
      default: w = '{MUL_NONE, ALU_NONE,    1'b0, 1'b0, BR_END,  '0};
    endcase
    return w;
  endfunction

endpackage

FILE: design/wspd_useq.sv
// ----------------------------------------------------------------------------
// wspd_useq: microcode sequencer
// Step counter, control store, loop counter and stall on a full output slot.
// ----------------------------------------------------------------------------
module wspd_useq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic            start_op,
  input  logic            out_free,
  output logic            busy,
  output wspd_pkg::ctl_t  ctl
);

  logic [wspd_pkg::UPC_W-1:0] upc_r, upc_nxt;
  logic [wspd_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                       busy_r, busy_nxt;
  wspd_pkg::ucode_t           cw;
  logic                       stall;
  logic                       run;

  assign cw    = wspd_pkg::ucode_rom(upc_r);
  assign stall = cw.emit && !out_free;
  assign run   = busy_r && !stall;

  // Next state
  always_comb begin
    upc_nxt  = upc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      upc_nxt  = (start_op == wspd_pkg::OP_TICK) ? wspd_pkg::TICK_ENTRY
                                                 : wspd_pkg::SAMPLE_ENTRY;
      cnt_nxt  = wspd_pkg::DIV_LAST;
      busy_nxt = 1'b1;
    end else if (run) begin
      unique case (cw.br)
        wspd_pkg::BR_NEXT: upc_nxt = upc_r + 1'b1;
        wspd_pkg::BR_LOOP: begin
          if (cnt_r != '0) begin
            cnt_nxt = cnt_r - 1'b1;
            upc_nxt = cw.target;
          end else begin
            upc_nxt = upc_r + 1'b1;
          end
        end
        wspd_pkg::BR_END:  busy_nxt = 1'b0;
        default:           busy_nxt = 1'b0;
      endcase
    end
  end

  // Outputs: drop the control word while idle or stalled
  always_comb begin
    busy       = busy_r;
    ctl.mul    = wspd_pkg::MUL_NONE;
    ctl.alu    = wspd_pkg::ALU_NONE;
    ctl.commit = 1'b0;
    ctl.emit   = 1'b0;
    if (run) begin
      ctl.mul    = cw.mul;
      ctl.alu    = cw.alu;
      ctl.commit = cw.commit;
      ctl.emit   = cw.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r  <= '0;
      cnt_r  <= '0;
      busy_r <= 1'b0;
    end else begin
      upc_r  <= upc_nxt;
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("item started while sequencer busy");

  a_end_emits: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> $past(ctl.emit))
    else $error("program ended without emitting a result");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && stall |=> busy_r && upc_r == $past(upc_r))
    else $error("step advanced while output slot full");

endmodule

FILE: design/wspd_dp.sv
// ----------------------------------------------------------------------------
// wspd_dp: controller datapath
// Config registers, state, one shared multiplier, accumulator, ramp divider.
// ----------------------------------------------------------------------------
module wspd_dp #(
  parameter int RAMP_STEPS = 20
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [wspd_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [31:0]                       cfg_wdata,
  input  logic                              start,
  input  logic                              op,
  input  logic [11:0]                       left_count,
  input  logic [11:0]                       right_count,
  input  logic                              reverse,
  input  logic [4:0]                        tick_index,
  input  wspd_pkg::ctl_t                    ctl,
  output logic [79:0]                       out_data
);

  localparam int PW = wspd_pkg::PROD_W;
  localparam int AW = wspd_pkg::ACC_W;

  // Configuration
  logic [31:0] set_r,   set_nxt;
  logic [30:0] scale_r, scale_nxt;
  logic [7:0]  dg_r,    dg_nxt;
  logic [7:0]  pg_r,    pg_nxt;
  logic [11:0] lim_r,   lim_nxt;

  // Controller state
  logic [31:0] prev_r,  prev_nxt;
  logic [39:0] old_r,   old_nxt;
  logic [39:0] new_r,   new_nxt;
  logic [31:0] speed_r, speed_nxt;

  // Working registers
  logic [wspd_pkg::SUM_W-1:0]  sum_r,  sum_nxt;
  logic [wspd_pkg::TICK_W-1:0] tick_r, tick_nxt;
  logic                        over_r, over_nxt;
  logic [31:0]                 err_r,  err_nxt;
  logic [wspd_pkg::MA_W-1:0]   tmp_r,  tmp_nxt;
  logic [PW-1:0]               prod_r, prod_nxt;
  logic [AW-1:0]               acc_r,  acc_nxt;
  logic                        neg_r,  neg_nxt;
  logic [wspd_pkg::DVD_W-1:0]  dvd_r,  dvd_nxt;
  logic [wspd_pkg::DVD_W-1:0]  quo_r,  quo_nxt;
  logic [wspd_pkg::REM_W-1:0]  rem_r,  rem_nxt;
  logic [79:0]                 out_r,  out_nxt;

  logic [wspd_pkg::MA_W-1:0]   mul_a;
  logic [wspd_pkg::MB_W-1:0]   mul_b;
  logic signed [PW-1:0]        mul_full;
  logic [12:0]                 cnt_sum;
  logic [wspd_pkg::SUM_W-1:0]  sum_pos;
  logic [32:0]                 err_raw;
  logic [PW-1:0]               prod_mag;
  logic [wspd_pkg::CUR_W-1:0]  div_cur;
  logic [wspd_pkg::CUR_W-1:0]  div_sub;
  logic [wspd_pkg::DIG_W-1:0]  div_dig;
  logic [AW-1:0]               quo_ext;
  logic [39:0]                 acc_sat;

  function automatic logic [31:0] sat_to32(input logic [45:0] v);
    if (v[45:31] == {15{v[45]}}) return v[31:0];
    return v[45] ? 32'h8000_0000 : 32'h7fff_ffff;
  endfunction

  function automatic logic [39:0] sat_to40(input logic [AW-1:0] v);
    if (v[AW-1:39] == {(AW-39){v[AW-1]}}) return v[39:0];
    return v[AW-1] ? 40'h80_0000_0000 : 40'h7f_ffff_ffff;
  endfunction

  // Shared multiplier operand select
  always_comb begin
    unique case (ctl.mul)
      wspd_pkg::MUL_SPEED: begin
        mul_a = {11'b0, scale_r};
        mul_b = {sum_r[wspd_pkg::SUM_W-1], sum_r};
      end
      wspd_pkg::MUL_PROP: begin
        mul_a = {{10{err_r[31]}}, err_r};
        mul_b = {7'b0, pg_r};
      end
      wspd_pkg::MUL_DIFF: begin
        mul_a = tmp_r;
        mul_b = {7'b0, dg_r};
      end
      wspd_pkg::MUL_TICK: begin
        mul_a = tmp_r;
        mul_b = {8'b0, tick_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_full = $signed(mul_a) * $signed(mul_b);

  assign cnt_sum  = {1'b0, left_count} + {1'b0, right_count};
  assign sum_pos  = {1'b0, cnt_sum};
  assign err_raw  = {set_r[31], set_r} - {speed_r[31], speed_r};
  assign prod_mag = prod_r[PW-1] ? (PW'(0) - prod_r) : prod_r;
  assign div_cur  = {rem_r, dvd_r[wspd_pkg::DVD_W-1 -: wspd_pkg::DIG_W]};
  assign quo_ext  = {{(AW-wspd_pkg::Q_W){1'b0}}, quo_r[wspd_pkg::Q_W-1:0]};
  assign acc_sat  = sat_to40(acc_r);

  // One radix-16 quotient digit against constant multiples of the divisor
  always_comb begin
    div_dig = '0;
    div_sub = '0;
    for (int k = 1; k < (1 << wspd_pkg::DIG_W); k++) begin
      if (div_cur >= wspd_pkg::CUR_W'(k * RAMP_STEPS)) begin
        div_dig = wspd_pkg::DIG_W'(k);
        div_sub = wspd_pkg::CUR_W'(k * RAMP_STEPS);
      end
    end
  end

  always_comb begin
    set_nxt   = set_r;
    scale_nxt = scale_r;
    dg_nxt    = dg_r;
    pg_nxt    = pg_r;
    lim_nxt   = lim_r;
    prev_nxt  = prev_r;
    old_nxt   = old_r;
    new_nxt   = new_r;
    speed_nxt = speed_r;
    sum_nxt   = sum_r;
    tick_nxt  = tick_r;
    over_nxt  = over_r;
    err_nxt   = err_r;
    tmp_nxt   = tmp_r;
    prod_nxt  = prod_r;
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    dvd_nxt   = dvd_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    out_nxt   = out_r;

    if (cfg_we) begin
      case (cfg_idx)
        wspd_pkg::CFG_SETPOINT:  set_nxt   = cfg_wdata;
        wspd_pkg::CFG_SCALE:     scale_nxt = cfg_wdata[30:0];
        wspd_pkg::CFG_DIFF_GAIN: dg_nxt    = cfg_wdata[7:0];
        wspd_pkg::CFG_PROP_GAIN: pg_nxt    = cfg_wdata[7:0];
        wspd_pkg::CFG_OVER_LIM:  lim_nxt   = cfg_wdata[11:0];
        default: ;
      endcase
    end

    // Capture the item; tick beyond the ramp clamps to its end
    if (start) begin
      sum_nxt  = reverse ? (wspd_pkg::SUM_W'(0) - sum_pos) : sum_pos;
      tick_nxt = ({2'b0, tick_index} > wspd_pkg::TICK_W'(RAMP_STEPS))
                 ? wspd_pkg::TICK_W'(RAMP_STEPS) : {2'b0, tick_index};
      over_nxt = (op == wspd_pkg::OP_SAMPLE) && (right_count > lim_r);
    end

    if (ctl.mul != wspd_pkg::MUL_NONE) begin
      prod_nxt = mul_full;
    end

    unique case (ctl.alu)
      wspd_pkg::ALU_NONE: ;
      // prod >>> 1 floors toward minus infinity
      wspd_pkg::ALU_SPEED:   speed_nxt = sat_to32(prod_r[46:1]);
      wspd_pkg::ALU_ERR:     err_nxt   = sat_to32({{13{err_raw[32]}}, err_raw});
      wspd_pkg::ALU_EDIFF:   tmp_nxt   = {{10{err_r[31]}}, err_r}
                                       - {{10{prev_r[31]}}, prev_r};
      wspd_pkg::ALU_ACC_LD:  acc_nxt   = prod_r[AW-1:0];
      wspd_pkg::ALU_ACC_ADD: acc_nxt   = acc_r + prod_r[AW-1:0];
      wspd_pkg::ALU_ODIFF:   tmp_nxt   = {{2{new_r[39]}}, new_r}
                                       - {{2{old_r[39]}}, old_r};
      wspd_pkg::ALU_DIV_INIT: begin
        neg_nxt = prod_r[PW-1];
        dvd_nxt = prod_mag[wspd_pkg::DVD_W-1:0];
        quo_nxt = '0;
        rem_nxt = '0;
      end
      wspd_pkg::ALU_DIV_STEP: begin
        dvd_nxt = {dvd_r[wspd_pkg::DVD_W-wspd_pkg::DIG_W-1:0], {wspd_pkg::DIG_W{1'b0}}};
        quo_nxt = {quo_r[wspd_pkg::DVD_W-wspd_pkg::DIG_W-1:0], div_dig};
        rem_nxt = wspd_pkg::REM_W'(div_cur - div_sub);
      end
      // Quotient magnitude truncates, so the sign goes on afterward
      wspd_pkg::ALU_RAMP: acc_nxt = {{(AW-40){old_r[39]}}, old_r}
                                  + (neg_r ? (AW'(0) - quo_ext) : quo_ext);
      default: ;
    endcase

    if (ctl.commit) begin
      prev_nxt = err_r;
      old_nxt  = new_r;
      new_nxt  = acc_sat;
    end

    if (ctl.emit) begin
      out_nxt = {7'b0, over_r, speed_r, acc_sat};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_r   <= 32'd655360;
      scale_r <= 31'd65536;
      dg_r    <= 8'd5;
      pg_r    <= 8'd50;
      lim_r   <= 12'd3000;
      prev_r  <= '0;
      old_r   <= '0;
      new_r   <= '0;
      speed_r <= '0;
    end else begin
      set_r   <= set_nxt;
      scale_r <= scale_nxt;
      dg_r    <= dg_nxt;
      pg_r    <= pg_nxt;
      lim_r   <= lim_nxt;
      prev_r  <= prev_nxt;
      old_r   <= old_nxt;
      new_r   <= new_nxt;
      speed_r <= speed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r  <= sum_nxt;
    tick_r <= tick_nxt;
    over_r <= over_nxt;
    err_r  <= err_nxt;
    tmp_r  <= tmp_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    neg_r  <= neg_nxt;
    dvd_r  <= dvd_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    out_r  <= out_nxt;
  end

  assign out_data = out_r;

endmodule

FILE: design/wheel_speed_pd_with_output_ramp.sv
// ----------------------------------------------------------------------------
// wheel_speed_pd_with_output_ramp: wheel speed PD controller with output ramp
// Microcoded controller over one shared multiplier and a radix-16 divider.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   stream: tuser selects the operation (0 sample, 1 ramp tick),
//          tdata carries the encoder counts, reverse flag and tick index.
//   out_*  stream: one result per item, drive value, measured speed and
//          overspeed flag, held in an output register until transferred.
//   cfg_*  write channel: index picks the register, always ready; write only
//          while no item is in flight.
// Timing: a sample runs 7 microcode steps, bounded by the single multiplier
//   (scale, prop and diff products in turn). A tick is set by the 12-step
//   radix-16 divide by RAMP_STEPS. A new item is taken only once the program
//   of the previous item has ended, so items never overlap in the sequencer.
// A new item is taken while the previous result still waits; if the output
//   register is still full when a result is due, the sequencer holds on that
//   step until out_tready frees it.
// Reset loads the default configuration and clears the controller state.
// ----------------------------------------------------------------------------
module wheel_speed_pd_with_output_ramp #(
  parameter int RAMP_STEPS = 20
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [31:0]                    in_tdata,  // left_count[11:0], right_count[23:12],
                                                    // reverse[24], tick_index[29:25]
  input  logic                           in_tuser,  // operation
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [79:0]                    out_tdata, // drive_value[39:0],
                                                    // measured_speed[71:40], overspeed[72]
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [wspd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data
);

  logic           busy;
  logic           start;
  logic           out_free;
  logic           out_valid_r, out_valid_nxt;
  wspd_pkg::ctl_t ctl;

  assign in_tready = !busy;
  assign start     = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  wspd_useq u_useq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .start_op (in_tuser),
    .out_free (out_free),
    .busy     (busy),
    .ctl      (ctl)
  );

  wspd_dp #(
    .RAMP_STEPS (RAMP_STEPS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_idx     (cfg_index),
    .cfg_wdata   (cfg_data),
    .start       (start),
    .op          (in_tuser),
    .left_count  (in_tdata[11:0]),
    .right_count (in_tdata[23:12]),
    .reverse     (in_tdata[24]),
    .tick_index  (in_tdata[29:25]),
    .ctl         (ctl),
    .out_data    (out_tdata)
  );

endmodule

FILE: dv/wspd_result_check.sv
// ----------------------------------------------------------------------------
// wspd_result_check: result checker for the wheel speed PD controller
// Watches the input, result and register channels, keeps its own copy of the
// controller state and settings, and compares every result field with the
// prediction for the oldest outstanding item.
// ----------------------------------------------------------------------------
module wspd_result_check #(
  parameter int RAMP_STEPS = 20
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [31:0]                    in_tdata,
  input  logic                           in_tuser,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [79:0]                    out_tdata,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [wspd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  output int                             fail_count,
  output int                             pending
);

  typedef struct packed {
    logic signed [39:0] drive;
    logic signed [31:0] speed;
    logic               over;
  } wheel_result_t;

  // register copies
  logic signed [31:0] setpoint;
  logic [30:0]        scale;
  logic [7:0]         kd;
  logic [7:0]         kp;
  logic [11:0]        over_lim;

  // controller state
  logic signed [31:0] last_err;
  logic signed [31:0] speed_now;
  logic signed [39:0] drive_old;
  logic signed [39:0] drive_new;

  wheel_result_t drive_expected[$];
  wheel_result_t want;
  wheel_result_t got;
  int            mismatches;

  function automatic longint saturate(input longint v, input int bits);
    longint hi;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // Advance the controller by one item and return the result it gives.
  function automatic wheel_result_t control_step(input logic op, input logic [11:0] lcnt,
                                                 input logic [11:0] rcnt, input logic rv,
                                                 input logic [4:0] tk);
    wheel_result_t res;
    longint        sum;
    longint        prod;
    longint        err;
    longint        ctl;
    longint        steps;
    longint        span;
    res.over = 1'b0;
    if (op == wspd_pkg::OP_SAMPLE) begin
      sum = longint'(lcnt) + longint'(rcnt);
      if (rv) sum = -sum;
      // halve with rounding toward minus infinity
      prod = (sum * longint'(scale)) >>> 1;
      speed_now = 32'(saturate(prod, 32));
      err = saturate(longint'(setpoint) - longint'(speed_now), 32);
      ctl = longint'(kd) * (err - longint'(last_err)) + longint'(kp) * err;
      last_err = 32'(err);
      drive_old = drive_new;
      drive_new = 40'(saturate(ctl, 40));
      res.over = (rcnt > over_lim);
      res.drive = drive_new;
    end else begin
      steps = (tk > RAMP_STEPS) ? RAMP_STEPS : tk;
      span = longint'(drive_new) - longint'(drive_old);
      res.drive = 40'(saturate(longint'(drive_old) + (steps * span) / RAMP_STEPS, 40));
    end
    res.speed = speed_now;
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      setpoint = 32'sd655360;
      scale = 31'd65536;
      kd = 8'd5;
      kp = 8'd50;
      over_lim = 12'd3000;
      last_err = '0;
      speed_now = '0;
      drive_old = '0;
      drive_new = '0;
      drive_expected.delete();
      mismatches = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.drive = out_tdata[39:0];
        got.speed = out_tdata[71:40];
        got.over = out_tdata[72];
        if (drive_expected.size() == 0) begin
          mismatches++;
          $error("result with none outstanding: drive_value %0d measured_speed %0d %s %0d",
                 got.drive, got.speed, "overspeed", got.over);
        end else begin
          want = drive_expected.pop_front();
          if (got.drive !== want.drive) begin
            mismatches++;
            $error("drive_value: expected %0d, got %0d", want.drive, got.drive);
          end
          if (got.speed !== want.speed) begin
            mismatches++;
            $error("measured_speed: expected %0d, got %0d", want.speed, got.speed);
          end
          if (got.over !== want.over) begin
            mismatches++;
            $error("overspeed: expected %0d, got %0d", want.over, got.over);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          wspd_pkg::CFG_SETPOINT:  setpoint = cfg_data;
          wspd_pkg::CFG_SCALE:     scale = cfg_data[30:0];
          wspd_pkg::CFG_DIFF_GAIN: kd = cfg_data[7:0];
          wspd_pkg::CFG_PROP_GAIN: kp = cfg_data[7:0];
          wspd_pkg::CFG_OVER_LIM:  over_lim = cfg_data[11:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        drive_expected.push_back(control_step(in_tuser, in_tdata[11:0], in_tdata[23:12],
                                              in_tdata[24], in_tdata[29:25]));
      end
    end
    fail_count <= mismatches;
    pending <= drive_expected.size();
  end

endmodule

FILE: dv/wheel_speed_pd_with_output_ramp_test.sv
// ----------------------------------------------------------------------------
// wheel_speed_pd_with_output_ramp_test: testbench for the wheel speed PD block
// Drives directed and random samples and ramp ticks under several register
// settings with random idling on both streams, one long output stall and
// drains between settings; the result checker compares every result.
// ----------------------------------------------------------------------------
module wheel_speed_pd_with_output_ramp_test;

  localparam int RAMP        = 20;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_LEN    = 300;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 108;
  localparam logic [wspd_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam logic [31:0] S32_MIN = 32'h8000_0000;
  localparam logic [31:0] S32_MAX = 32'h7fff_ffff;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [31:0]                    in_tdata;
  logic                           in_tuser;
  logic                           out_tvalid;
  logic                           out_tready;
  logic [79:0]                    out_tdata;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [wspd_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [31:0]                    cfg_data;

  int fail_count;
  int pending;
  int items_sent;
  int samples_sent;
  int ticks_sent;
  int reg_writes;
  int settings_used;
  int hold_asked;
  int hold_served;
  int quiet_cycles = 0;
  bit in_gaps;
  bit out_gaps;

  always #1 clk = ~clk;

  wheel_speed_pd_with_output_ramp #(
    .RAMP_STEPS(RAMP)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  wspd_result_check #(
    .RAMP_STEPS(RAMP)
  ) result_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  function automatic logic [11:0] pick_count();
    int roll;
    roll = $urandom_range(9);
    if (roll == 0) return 12'd0;
    if (roll == 1) return 12'd4095;
    return 12'($urandom_range(4095));
  endfunction

  function automatic logic [4:0] pick_tick();
    if ($urandom_range(9) < 8) return 5'($urandom_range(RAMP));
    return 5'($urandom_range(31, RAMP + 1));
  endfunction

  task automatic send_item(input logic op, input logic [11:0] lcnt, input logic [11:0] rcnt,
                           input logic rv, input logic [4:0] tk);
    @(negedge clk);
    while (in_gaps && $urandom_range(99) < 33) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {2'b00, tk, rv, rcnt, lcnt};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_sample(input logic [11:0] lcnt, input logic [11:0] rcnt, input logic rv);
    send_item(wspd_pkg::OP_SAMPLE, lcnt, rcnt, rv, 5'($urandom));
    samples_sent++;
  endtask

  task automatic send_tick(input logic [4:0] tk);
    send_item(wspd_pkg::OP_TICK, 12'($urandom), 12'($urandom), 1'($urandom), tk);
    ticks_sent++;
  endtask

  // Hold off new items until every outstanding result has been transferred.
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [wspd_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    reg_writes++;
  endtask

  task automatic write_settings(input logic [31:0] sp, input logic [31:0] sc,
                                input logic [31:0] kd, input logic [31:0] kp,
                                input logic [31:0] lim);
    write_reg(wspd_pkg::CFG_SETPOINT, sp);
    write_reg(wspd_pkg::CFG_SCALE, sc);
    write_reg(wspd_pkg::CFG_DIFF_GAIN, kd);
    write_reg(wspd_pkg::CFG_PROP_GAIN, kp);
    write_reg(wspd_pkg::CFG_OVER_LIM, lim);
    settings_used++;
  endtask

  task automatic random_settings();
    logic [31:0] sp;
    logic [31:0] sc;
    sp = $urandom_range(1) ? $urandom : 32'($urandom_range(2097152) - 1048576);
    sc = $urandom_range(1) ? $urandom : 32'($urandom_range(262144));
    write_settings(sp, sc, $urandom_range(255), $urandom_range(255), $urandom_range(4095));
    // an index past the register list must change nothing
    if ($urandom_range(2) == 0) write_reg(CFG_UNUSED, $urandom);
  endtask

  task automatic random_run(input int n);
    int stop;
    int roll;
    int k;
    stop = items_sent + n;
    while (items_sent < stop) begin
      roll = $urandom_range(99);
      if (roll < 15) begin
        // new output followed by a sweep of the ramp
        send_sample(pick_count(), pick_count(), 1'($urandom));
        for (k = 0; k <= RAMP; k += 1 + $urandom_range(5)) send_tick(5'(k));
      end else if (roll < 60) begin
        send_sample(pick_count(), pick_count(), 1'($urandom));
      end else begin
        send_tick(pick_tick());
      end
    end
  endtask

  // Result side: random stalls, plus a long hold when the sender asks for one.
  initial begin
    out_tready = 1'b0;
    hold_served = 0;
    forever begin
      @(negedge clk);
      if (hold_served != hold_asked) begin
        hold_served++;
        out_tready <= 1'b0;
        repeat (HOLD_LEN - 1) @(negedge clk);
      end else if (out_gaps && $urandom_range(99) < 33) begin
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $error("no transfer for %0d cycles, %0d results outstanding", quiet_cycles, pending);
      $display("wheel_speed_pd_with_output_ramp_test NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int p;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = wspd_pkg::OP_SAMPLE;
    cfg_valid = 1'b0;
    cfg_index = wspd_pkg::CFG_SETPOINT;
    cfg_data = '0;
    in_gaps = 1'b1;
    out_gaps = 1'b1;
    hold_asked = 0;
    items_sent = 0;
    samples_sent = 0;
    ticks_sent = 0;
    reg_writes = 0;
    settings_used = 1;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // default settings: zero and full counts, limit edge, ticks past the ramp
    send_sample(12'd0, 12'd0, 1'b0);
    send_tick(5'd0);
    send_tick(5'd10);
    send_tick(5'd20);
    send_tick(5'd31);
    send_sample(12'd4095, 12'd4095, 1'b0);
    send_tick(5'd21);
    send_sample(12'd4095, 12'd4095, 1'b1);
    send_tick(5'd7);
    send_sample(12'd0, 12'd3000, 1'b0);
    send_sample(12'd0, 12'd3001, 1'b0);
    send_sample(12'd2048, 12'd1, 1'b1);
    drain();

    // full scale and gains: saturate speed, error and output
    write_settings(S32_MIN, 32'hffff_ffff, 32'd255, 32'd255, 32'd0);
    send_sample(12'd4095, 12'd4095, 1'b0);
    send_tick(5'd19);
    send_sample(12'd4095, 12'd4095, 1'b1);
    send_tick(5'd1);
    send_sample(12'd0, 12'd0, 1'b0);
    drain();

    write_settings(S32_MAX, 32'd0, 32'd0, 32'd0, 32'd4095);
    write_reg(CFG_UNUSED, 32'hffff_ffff);
    send_sample(12'd4095, 12'd4095, 1'b0);
    send_tick(5'd20);
    send_sample(12'd1, 12'd4095, 1'b1);
    send_tick(5'd15);
    drain();

    write_settings(S32_MAX, S32_MAX, 32'd255, 32'd255, 32'd2048);
    send_sample(12'd4095, 12'd4095, 1'b1);
    send_tick(5'd20);
    send_tick(5'd10);
    drain();

    for (p = 0; p < PHASES; p++) begin
      random_settings();
      @(posedge clk);
      in_gaps = (p != 2);
      out_gaps = (p != 2);
      if (p == 1) begin
        random_run(40);
        hold_asked++;
        random_run(PHASE_ITEMS - 40);
      end else if (p == 3) begin
        random_run(50);
        drain();
        random_run(PHASE_ITEMS - 50);
      end else begin
        random_run(PHASE_ITEMS);
      end
      drain();
    end

    repeat (24) @(negedge clk);
    $display("covered %0d items: %0d samples and %0d ramp ticks", items_sent, samples_sent,
             ticks_sent);
    $display("%0d register writes over %0d settings, one %0d-cycle output stall",
             reg_writes, settings_used, HOLD_LEN);
    if (fail_count == 0 && pending == 0) begin
      $display("wheel_speed_pd_with_output_ramp_test OK");
    end else begin
      $display("wheel_speed_pd_with_output_ramp_test NOT OK");
    end
    $finish;
  end

endmodule
